[sv/wia_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wia_pkg
// Opcodes and fixed field widths of the wide integer accumulator ALU.
// ----------------------------------------------------------------------------
package wia_pkg;

	localparam int OpW     = 4;
	localparam int HalfW   = 64;
	localparam int ValueW  = 2 * HalfW;
	localparam int FactorW = 32;
	localparam int FactLgW = 5;
	localparam int AmountW = 8;
	localparam int CmpW    = 2;

	typedef enum logic [OpW-1:0] {
		OP_LOAD    = 4'd0,
		OP_FILL    = 4'd1,
		OP_AND     = 4'd2,
		OP_OR      = 4'd3,
		OP_XOR     = 4'd4,
		OP_ADD     = 4'd5,
		OP_SUB     = 4'd6,
		OP_INVERT  = 4'd7,
		OP_SHL     = 4'd8,
		OP_SHR     = 4'd9,
		OP_MULPOW2 = 4'd10,
		OP_DIVPOW2 = 4'd11,
		OP_COMPARE = 4'd12,
		OP_GETBIT  = 4'd13,
		OP_SETBIT  = 4'd14
	} opcode_t;

	// compare codes (two's complement -1, 0, +1)
	localparam logic [CmpW-1:0] CMP_LESS    = 2'b11;
	localparam logic [CmpW-1:0] CMP_EQUAL   = 2'b00;
	localparam logic [CmpW-1:0] CMP_GREATER = 2'b01;

endpackage
`default_nettype wire

[sv/wide_integer_accumulator_alu.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wide_integer_accumulator_alu
// WIDTH-bit unsigned accumulator ALU, one opcode applied per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries opcode, a 128-bit operand
//   (operand_high:operand_low, cut to WIDTH bits), amount, bit_in and
//   big_endian. Output channel (out_valid/out_ready) returns one result item
//   per input item: the accumulator after the step plus compare_result,
//   is_zero, bit_out and error.
//   An accepted item is registered into the execute stage, executes there
//   and lands in the output register when it leaves execute.
//   Throughput: one item per cycle while out_ready is high. The accumulator
//   lives in a one-entry synchronous memory with a registered read; the value
//   written at an edge is forwarded to the item executing in the next cycle,
//   so back-to-back items see each other's results.
//   Reset (arst_n low) clears all valid flags and marks the memory entry
//   unwritten, so the accumulator reads as zero. No clearing pass is needed.
//   When out_ready is low, the output register holds its item, the execute
//   stage holds its item, and in_ready drops once both are full.
// ----------------------------------------------------------------------------
module wide_integer_accumulator_alu #(
	parameter int WIDTH = 128
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  [wia_pkg::OpW-1:0]      opcode,
	input  wire  [wia_pkg::HalfW-1:0]    operand_low,
	input  wire  [wia_pkg::HalfW-1:0]    operand_high,
	input  wire  [wia_pkg::AmountW-1:0]  amount,
	input  wire                          bit_in,
	input  wire                          big_endian,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [wia_pkg::HalfW-1:0]    value_low,
	output logic [wia_pkg::HalfW-1:0]    value_high,
	output logic signed [wia_pkg::CmpW-1:0] compare_result,
	output logic                         is_zero,
	output logic                         bit_out,
	output logic                         error
);

	localparam int AccDepth = 1;
	localparam int IdxW     = $clog2(WIDTH);

	// execute stage
	logic                         valid_s1;
	wia_pkg::opcode_t             opcode_s1;
	logic [WIDTH-1:0]             operand_s1;
	logic [wia_pkg::AmountW-1:0]  amount_s1;
	logic                         bit_in_s1;
	logic                         big_endian_s1;
	logic                         adv_s1;

	// accumulator memory and forwarding
	logic [WIDTH-1:0]             acc_mem [AccDepth];
	logic [WIDTH-1:0]             rd_q;
	logic                         mem_vld_q;
	logic                         fwd_q;
	logic [WIDTH-1:0]             fwd_data_q;
	logic [WIDTH-1:0]             acc_cur;

	// result of the step
	logic [WIDTH-1:0]             nxt_value;
	logic [wia_pkg::CmpW-1:0]     nxt_cmp;
	logic                         nxt_bit;
	logic                         nxt_err;
	logic [wia_pkg::ValueW-1:0]   nxt_ext;

	logic [wia_pkg::FactorW-1:0]  factor;
	logic                         fact_zero;
	logic                         fact_pow2;
	logic [wia_pkg::FactLgW-1:0]  fact_lg;
	logic                         idx_ok;
	logic [IdxW-1:0]              bit_idx;
	logic [WIDTH-1:0]             set_value;

	// output register
	logic                         out_valid_q;

	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1     <= wia_pkg::opcode_t'(opcode);
			operand_s1    <= WIDTH'({operand_high, operand_low});
			amount_s1     <= amount;
			bit_in_s1     <= bit_in;
			big_endian_s1 <= big_endian;
		end
	end

	// memory: written when an item leaves execute, read every cycle
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			acc_mem[0] <= nxt_value;
		end
		rd_q <= acc_mem[0];
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			fwd_data_q <= nxt_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_vld_q <= 1'b0;
			fwd_q     <= 1'b0;
		end else begin
			fwd_q <= adv_s1;
			if (adv_s1) begin
				mem_vld_q <= 1'b1;
			end
		end
	end

	// read data lags a write made at the same edge: take the forwarded copy
	assign acc_cur = fwd_q ? fwd_data_q : (mem_vld_q ? rd_q : '0);

	// power-of-two factor decode
	assign factor    = operand_s1[wia_pkg::FactorW-1:0];
	assign fact_zero = (factor == '0);
	assign fact_pow2 = !fact_zero && ((factor & (factor - 1'b1)) == '0);

	always_comb begin
		fact_lg = '0;
		for (int i = 0; i < wia_pkg::FactorW; i++) begin
			if (factor[i]) begin
				fact_lg = fact_lg | wia_pkg::FactLgW'(i);
			end
		end
	end

	// bit index, counted from the top when big_endian is set
	assign idx_ok  = (amount_s1 < wia_pkg::AmountW'(WIDTH));
	assign bit_idx = big_endian_s1 ?
		IdxW'(wia_pkg::AmountW'(WIDTH - 1) - amount_s1) : IdxW'(amount_s1);

	always_comb begin
		set_value          = acc_cur;
		set_value[bit_idx] = bit_in_s1;
	end

	always_comb begin
		nxt_value = acc_cur;
		nxt_cmp   = wia_pkg::CMP_EQUAL;
		nxt_bit   = 1'b0;
		nxt_err   = 1'b0;
		unique case (opcode_s1)
			wia_pkg::OP_LOAD:    nxt_value = operand_s1;
			wia_pkg::OP_FILL:    nxt_value = {WIDTH{bit_in_s1}};
			wia_pkg::OP_AND:     nxt_value = acc_cur & operand_s1;
			wia_pkg::OP_OR:      nxt_value = acc_cur | operand_s1;
			wia_pkg::OP_XOR:     nxt_value = acc_cur ^ operand_s1;
			wia_pkg::OP_ADD:     nxt_value = acc_cur + operand_s1;
			wia_pkg::OP_SUB:     nxt_value = acc_cur - operand_s1;
			wia_pkg::OP_INVERT:  nxt_value = ~acc_cur;
			wia_pkg::OP_SHL:     nxt_value = acc_cur << amount_s1;
			wia_pkg::OP_SHR:     nxt_value = acc_cur >> amount_s1;
			wia_pkg::OP_MULPOW2: begin
				if (fact_zero) begin
					nxt_value = '0;
				end else if (fact_pow2) begin
					nxt_value = acc_cur << fact_lg;
				end else begin
					nxt_err = 1'b1;
				end
			end
			wia_pkg::OP_DIVPOW2: begin
				if (fact_zero) begin
					nxt_value = '1;
				end else if (fact_pow2) begin
					nxt_value = acc_cur >> fact_lg;
				end else begin
					nxt_err = 1'b1;
				end
			end
			wia_pkg::OP_COMPARE: begin
				if (acc_cur < operand_s1) begin
					nxt_cmp = wia_pkg::CMP_LESS;
				end else if (acc_cur != operand_s1) begin
					nxt_cmp = wia_pkg::CMP_GREATER;
				end
			end
			wia_pkg::OP_GETBIT:  nxt_bit = idx_ok && acc_cur[bit_idx];
			wia_pkg::OP_SETBIT: begin
				if (idx_ok) begin
					nxt_value = set_value;
				end
			end
			default: ;
		endcase
	end

	assign nxt_ext = wia_pkg::ValueW'(nxt_value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			value_low      <= nxt_ext[wia_pkg::HalfW-1:0];
			value_high     <= nxt_ext[wia_pkg::ValueW-1:wia_pkg::HalfW];
			compare_result <= nxt_cmp;
			is_zero        <= (nxt_value == '0);
			bit_out        <= nxt_bit;
			error          <= nxt_err;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

[sv/wia_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wia_assertions
// Port-level checks on the result channel of the accumulator ALU.
// ----------------------------------------------------------------------------
module wia_assertions (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               out_valid,
	input wire                               out_ready,
	input wire [wia_pkg::HalfW-1:0]          value_low,
	input wire [wia_pkg::HalfW-1:0]          value_high,
	input wire [wia_pkg::CmpW-1:0]           compare_result,
	input wire                               is_zero,
	input wire                               bit_out,
	input wire                               error
);

	// a stalled result item keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value_low) &&
		$stable(value_high) && $stable(compare_result))
		else $error("result item changed while stalled");

	a_cmp_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> compare_result != 2'b10)
		else $error("illegal compare code");

	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> is_zero == (value_low == '0 && value_high == '0))
		else $error("is_zero disagrees with value");

	// status fields belong to different opcodes, at most one is set
	a_status_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones({error, bit_out, compare_result != 2'b00}) <= 1)
		else $error("more than one status field set");

endmodule

bind wide_integer_accumulator_alu wia_assertions u_wia_assertions (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.value_low      (value_low),
	.value_high     (value_high),
	.compare_result (compare_result),
	.is_zero        (is_zero),
	.bit_out        (bit_out),
	.error          (error)
);
`default_nettype wire
